@@ sv/ggh_pkg.sv @@
package ggh_pkg;

    // pipeline geometry
    localparam int CORDIC_STEPS = 16;
    localparam int ARR_LAT      = 3;
    localparam int PIPE_LAT     = CORDIC_STEPS + 3;
    localparam int MOV_DLY      = PIPE_LAT - ARR_LAT;
    localparam int HD_DLY       = CORDIC_STEPS + 2;

    // datapath widths
    localparam int POS_W   = 32;
    localparam int D_W     = 33;
    localparam int XY_W    = 36;
    localparam int Z_W     = 25;
    localparam int HD_W    = 16;
    localparam int GAIN_W  = 16;
    localparam int SPD_W   = 24;
    localparam int BRG_W   = Z_W - 6;
    localparam int ERR_W   = BRG_W + 1;
    localparam int PROD_W  = ERR_W + GAIN_W + 1;
    localparam int ANG_W   = 16;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    localparam int ANG_FRAC = 20;
    localparam logic signed [Z_W-1:0] PI_Z = Z_W'(3294199);

    // register map
    localparam logic [IDX_W-1:0] REG_TARGET_X       = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_Y       = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN           = 3'd2;
    localparam logic [IDX_W-1:0] REG_CRUISE_SPEED   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ARRIVAL_RADIUS = 3'd4;

    // atan(2^-i) in units of 2^-20 rad
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0: v = Z_W'(823550);
            1: v = Z_W'(486170);
            2: v = Z_W'(256879);
            3: v = Z_W'(130396);
            4: v = Z_W'(65451);
            5: v = Z_W'(32757);
            6: v = Z_W'(16383);
            7: v = Z_W'(8192);
            default: v = (i <= ANG_FRAC) ? Z_W'(1 << (ANG_FRAC - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/ggh_arrive.sv @@
module ggh_arrive
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ggh_pkg::D_W-1:0]    dx,
    input  logic signed [ggh_pkg::D_W-1:0]    dy,
    input  logic        [ggh_pkg::SPD_W-1:0]  radius,
    output logic                              moving
);

    logic [ggh_pkg::D_W-1:0]      adx;
    logic [ggh_pkg::D_W-1:0]      ady;
    logic                         big_reg;
    logic                         big2_reg;
    logic [ggh_pkg::SPD_W-1:0]    ax_reg;
    logic [ggh_pkg::SPD_W-1:0]    ay_reg;
    logic [ggh_pkg::SPD_W-1:0]    r_reg;
    logic [2*ggh_pkg::SPD_W-1:0]  sqx_reg;
    logic [2*ggh_pkg::SPD_W-1:0]  sqy_reg;
    logic [2*ggh_pkg::SPD_W-1:0]  rr_reg;
    logic                         moving_reg;

    // magnitudes of the offsets
    assign adx = dx[ggh_pkg::D_W-1] ? ggh_pkg::D_W'(-dx) : ggh_pkg::D_W'(dx);
    assign ady = dy[ggh_pkg::D_W-1] ? ggh_pkg::D_W'(-dy) : ggh_pkg::D_W'(dy);

    // coarse box test, then squares, then the sum compare
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg    <= (adx > ggh_pkg::D_W'(radius)) || (ady > ggh_pkg::D_W'(radius));
            ax_reg     <= adx[ggh_pkg::SPD_W-1:0];
            ay_reg     <= ady[ggh_pkg::SPD_W-1:0];
            r_reg      <= radius;
            big2_reg   <= big_reg;
            sqx_reg    <= ax_reg * ax_reg;
            sqy_reg    <= ay_reg * ay_reg;
            rr_reg     <= r_reg * r_reg;
            moving_reg <= big2_reg ||
                          (({1'b0, sqx_reg} + {1'b0, sqy_reg}) > {1'b0, rr_reg});
        end
    end

    assign moving = moving_reg;

endmodule

@@ sv/ggh_cordic.sv @@
module ggh_cordic
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ggh_pkg::D_W-1:0]    dx,
    input  logic signed [ggh_pkg::D_W-1:0]    dy,
    output logic signed [ggh_pkg::Z_W-1:0]    z
);

    logic signed [ggh_pkg::XY_W-1:0] x_reg [0:ggh_pkg::CORDIC_STEPS];
    logic signed [ggh_pkg::XY_W-1:0] y_reg [0:ggh_pkg::CORDIC_STEPS];
    logic signed [ggh_pkg::Z_W-1:0]  z_reg [0:ggh_pkg::CORDIC_STEPS];
    logic signed [ggh_pkg::XY_W-1:0] dxe;
    logic signed [ggh_pkg::XY_W-1:0] dye;

    assign dxe = ggh_pkg::XY_W'(dx);
    assign dye = ggh_pkg::XY_W'(dy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // fold the left half plane onto the right, preload +-pi
            if (dx[ggh_pkg::D_W-1])
            begin
                x_reg[0] <= -dxe;
                y_reg[0] <= -dye;
                z_reg[0] <= dy[ggh_pkg::D_W-1] ? -ggh_pkg::PI_Z : ggh_pkg::PI_Z;
            end
            else
            begin
                x_reg[0] <= dxe;
                y_reg[0] <= dye;
                z_reg[0] <= '0;
            end
            // one vectoring micro-rotation per stage
            for (int i = 0; i < ggh_pkg::CORDIC_STEPS; i++)
            begin
                if (!y_reg[i][ggh_pkg::XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ggh_pkg::atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ggh_pkg::atan_step(i);
                end
            end
        end
    end

    assign z = z_reg[ggh_pkg::CORDIC_STEPS];

endmodule

@@ sv/ggh_cmd.sv @@
module ggh_cmd
(
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [ggh_pkg::Z_W-1:0]     z,
    input  logic signed [ggh_pkg::HD_W-1:0]    hd,
    input  logic        [ggh_pkg::GAIN_W-1:0]  gain,
    output logic signed [ggh_pkg::ANG_W-1:0]   angular
);

    localparam int SUM_W = ggh_pkg::PROD_W + 1;
    localparam int W_W   = SUM_W - 8;

    logic signed [ggh_pkg::Z_W:0]        zr;
    logic signed [ggh_pkg::BRG_W-1:0]    brg;
    logic signed [ggh_pkg::ERR_W-1:0]    err;
    logic signed [ggh_pkg::PROD_W-1:0]   p_reg;
    logic signed [SUM_W-1:0]             ps;
    logic signed [W_W-1:0]               w;
    logic signed [ggh_pkg::ANG_W-1:0]    ang_reg;

    // bearing to Q3.13 with rounding, error, gain product
    assign zr  = (ggh_pkg::Z_W+1)'(z) + (ggh_pkg::Z_W+1)'(64);
    assign brg = zr[ggh_pkg::Z_W:7];
    assign err = ggh_pkg::ERR_W'(brg) - ggh_pkg::ERR_W'(hd);

    // round Q.21 to Q3.13 and saturate
    assign ps = SUM_W'(p_reg) + SUM_W'(128);
    assign w  = ps[SUM_W-1:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= ggh_pkg::PROD_W'(err) * $signed({1'b0, gain});
            if (w > W_W'(32767))
                ang_reg <= 16'sh7fff;
            else if (w < -W_W'(32768))
                ang_reg <= 16'sh8000;
            else
                ang_reg <= w[ggh_pkg::ANG_W-1:0];
        end
    end

    assign angular = ang_reg;

endmodule

@@ sv/go_to_goal_heading_controller_core.sv @@
// Go-to-goal heading controller.
// Input channel (in_valid/in_ready) takes one odometry request: pos_x, pos_y
// (Q16.16 m) and heading (Q3.13 rad). Output channel (out_valid/out_ready)
// returns one result per request: linear_cmd, angular_cmd and arrived.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), index
// 0..4 = goal x, goal y, gain, cruise speed, arrival radius; other
// indexes are ignored. Write only while no request is in flight.
// One request is accepted every cycle while the output is not stalled. The
// depth from acceptance to out_valid is set by the pipelined CORDIC, one fold
// stage and one micro-rotation per stage, plus offset and gain-multiply
// stages and the rounding/saturation register.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated. Bubbles pass through as
// invalid stages.
// Reset clears all valid bits and loads the default registers: target at
// the origin, gain 0.5, cruise 0.15 m/s, arrival radius 0.1 m.
module go_to_goal_heading_controller_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ggh_pkg::POS_W-1:0]       pos_x,
    input  logic signed [ggh_pkg::POS_W-1:0]       pos_y,
    input  logic signed [ggh_pkg::HD_W-1:0]        heading,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic        [ggh_pkg::SPD_W-1:0]       linear_cmd,
    output logic signed [ggh_pkg::ANG_W-1:0]       angular_cmd,
    output logic                                   arrived,
    input  logic                                   cfg_we,
    input  logic        [ggh_pkg::IDX_W-1:0]       cfg_index,
    input  logic        [ggh_pkg::CFG_W-1:0]       cfg_data
);

    logic signed [ggh_pkg::POS_W-1:0]  goal_x_reg;
    logic signed [ggh_pkg::POS_W-1:0]  goal_y_reg;
    logic        [ggh_pkg::GAIN_W-1:0] gain_reg;
    logic        [ggh_pkg::SPD_W-1:0]  cruise_reg;
    logic        [ggh_pkg::SPD_W-1:0]  radius_reg;

    logic                              v_reg  [0:ggh_pkg::PIPE_LAT];
    logic signed [ggh_pkg::D_W-1:0]    dx_reg;
    logic signed [ggh_pkg::D_W-1:0]    dy_reg;
    logic signed [ggh_pkg::HD_W-1:0]   hd_reg [0:ggh_pkg::HD_DLY-1];
    logic                              mov_reg [0:ggh_pkg::MOV_DLY-1];

    logic                              en;
    logic                              moving;
    logic                              mov_out;
    logic signed [ggh_pkg::Z_W-1:0]    z;
    logic signed [ggh_pkg::ANG_W-1:0]  ang;

    // global advance: hold everything while a result waits
    assign en       = !v_reg[ggh_pkg::PIPE_LAT] || out_ready;
    assign in_ready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            gain_reg     <= 16'd128;
            cruise_reg   <= 24'd9830;
            radius_reg   <= 24'd6554;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ggh_pkg::REG_TARGET_X:       goal_x_reg <= cfg_data;
                ggh_pkg::REG_TARGET_Y:       goal_y_reg <= cfg_data;
                ggh_pkg::REG_GAIN:           gain_reg <= cfg_data[ggh_pkg::GAIN_W-1:0];
                ggh_pkg::REG_CRUISE_SPEED:   cruise_reg <= cfg_data[ggh_pkg::SPD_W-1:0];
                ggh_pkg::REG_ARRIVAL_RADIUS: radius_reg <= cfg_data[ggh_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ggh_pkg::PIPE_LAT; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= ggh_pkg::PIPE_LAT; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // offsets to target, heading and arrival delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= ggh_pkg::D_W'(goal_x_reg) - ggh_pkg::D_W'(pos_x);
            dy_reg    <= ggh_pkg::D_W'(goal_y_reg) - ggh_pkg::D_W'(pos_y);
            hd_reg[0] <= heading;
            for (int i = 1; i < ggh_pkg::HD_DLY; i++)
                hd_reg[i] <= hd_reg[i-1];
            mov_reg[0] <= moving;
            for (int i = 1; i < ggh_pkg::MOV_DLY; i++)
                mov_reg[i] <= mov_reg[i-1];
        end
    end

    ggh_arrive u_arrive
    (
        .clk    (clk),
        .en     (en),
        .dx     (dx_reg),
        .dy     (dy_reg),
        .radius (radius_reg),
        .moving (moving)
    );

    ggh_cordic u_cordic
    (
        .clk (clk),
        .en  (en),
        .dx  (dx_reg),
        .dy  (dy_reg),
        .z   (z)
    );

    ggh_cmd u_cmd
    (
        .clk     (clk),
        .en      (en),
        .z       (z),
        .hd      (hd_reg[ggh_pkg::HD_DLY-1]),
        .gain    (gain_reg),
        .angular (ang)
    );

    // result select
    assign mov_out     = mov_reg[ggh_pkg::MOV_DLY-1];
    assign out_valid   = v_reg[ggh_pkg::PIPE_LAT];
    assign linear_cmd  = mov_out ? cruise_reg : '0;
    assign angular_cmd = mov_out ? ang : '0;
    assign arrived     = !mov_out;

endmodule
